// ----- src/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, constants and the byte-wide CRC step for the space packet
// deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

   // apid entry table
   localparam int MAX_APID_ENTRIES     = 4;
   localparam int DEFAULT_APID_ENTRIES = 4;
   localparam int APID_W               = 12;
   localparam int ENTRY_COUNT_W        = 3;
   localparam int MATCH_W              = 2;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_PACKET_VERSION = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PACKET_TYPE    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_APID_ENTRY_0   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_APID_ENTRY_1   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_APID_ENTRY_2   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_APID_ENTRY_3   = 3'd6;

   localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 3'd3;

   // crc-16 ccitt-false
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // field part codes
   localparam logic [1:0] PART_HEADER  = 2'd0;
   localparam logic [1:0] PART_PAYLOAD = 2'd1;
   localparam logic [1:0] PART_CRC     = 2'd2;

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_SEQ,
      PH_LEN,
      PH_PAY,
      PH_CRC
   } phase_type;

   typedef struct packed {
      logic [2:0]               packet_version;
      logic                     type_bit;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               packet_start;
      logic               packet_end;
      logic [1:0]         field_part;
      logic               crc_good;
      logic [MATCH_W-1:0] matched_entry;
   } result_type;

   typedef struct packed {
      logic [1:0] push_count;
      result_type first;
      result_type second;
   } push_type;

   // reset value of an apid entry
   function automatic logic [APID_W-1:0] apid_reset(input int idx);
      logic [APID_W-1:0] val;
      unique case (idx)
         0:       val = 12'd2171;
         1:       val = 12'd2863;
         2:       val = 12'd2047;
         default: val = 12'd0;
      endcase
      return val;
   endfunction

   // one byte through the crc, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- src/spd_csr.sv -----
// ----------------------------------------------------------------------------
// spd_csr
// Register file on the apb-style port: version, type, entry count and the
// apid entries used for sync word matching.
// ----------------------------------------------------------------------------
module spd_csr #(
   parameter int NUM_APID_ENTRIES = spd_pkg::DEFAULT_APID_ENTRIES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [spd_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [spd_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [spd_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready,
   output spd_pkg::cfg_type                       cfg,
   output logic [NUM_APID_ENTRIES-1:0][spd_pkg::APID_W-1:0] apid_entry
);
   import spd_pkg::*;

   logic [2:0]               version_ff;
   logic                     type_ff;
   logic [ENTRY_COUNT_W-1:0] count_ff;
   logic [NUM_APID_ENTRIES-1:0][APID_W-1:0] entry_ff;

   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[REG_IDX_W+1:2];

   // scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= '0;
         type_ff    <= 1'b0;
         count_ff   <= ENTRY_COUNT_RESET;
      end else if (wr_en) begin
         if (reg_idx == REG_PACKET_VERSION) version_ff <= pwdata[2:0];
         if (reg_idx == REG_PACKET_TYPE)    type_ff    <= pwdata[0];
         if (reg_idx == REG_ENTRY_COUNT)    count_ff   <= pwdata[ENTRY_COUNT_W-1:0];
      end
   end

   // apid entries
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_APID_ENTRIES; i++) begin
         if (reset) begin
            entry_ff[i] <= apid_reset(i);
         end else if (wr_en && (reg_idx == REG_APID_ENTRY_0 + REG_IDX_W'(i))) begin
            entry_ff[i] <= pwdata[APID_W-1:0];
         end
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_PACKET_VERSION: prdata[2:0] = version_ff;
         REG_PACKET_TYPE:    prdata[0]   = type_ff;
         REG_ENTRY_COUNT:    prdata[ENTRY_COUNT_W-1:0] = count_ff;
         default: begin
            for (int i = 0; i < NUM_APID_ENTRIES; i++) begin
               if (reg_idx == REG_APID_ENTRY_0 + REG_IDX_W'(i)) begin
                  prdata[APID_W-1:0] = entry_ff[i];
               end
            end
         end
      endcase
   end

   assign cfg.packet_version = version_ff;
   assign cfg.type_bit       = type_ff;
   assign cfg.entry_count    = count_ff;
   assign apid_entry         = entry_ff;

endmodule

// ----- src/spd_core.sv -----
// ----------------------------------------------------------------------------
// spd_core
// Deframer state machine: sync hunt over a two-byte window, header, payload
// and crc phases, with the running crc updated one byte per transfer.
// ----------------------------------------------------------------------------
module spd_core #(
   parameter int NUM_APID_ENTRIES = spd_pkg::DEFAULT_APID_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  spd_pkg::cfg_type     cfg,
   input  logic [NUM_APID_ENTRIES-1:0][spd_pkg::APID_W-1:0] apid_entry,
   output spd_pkg::push_type    push
);
   import spd_pkg::*;

   phase_type          phase_ff,   phase_in;
   logic [7:0]         held_ff,    held_in;
   logic               hvalid_ff,  hvalid_in;
   logic [15:0]        count_ff,   count_in;
   logic [15:0]        plen_ff,    plen_in;
   logic [15:0]        crc_ff,     crc_in;
   logic [MATCH_W-1:0] match_ff,   match_in;

   logic [ENTRY_COUNT_W-1:0] entry_limit;
   logic [15:0]              word;
   logic                     hit;
   logic [MATCH_W-1:0]       hit_idx;
   logic [15:0]              crc_next;
   logic [15:0]              len_word;
   logic [15:0]              count_inc;

   assign word      = {held_ff, data_byte};
   assign crc_next  = crc_byte(crc_ff, data_byte);
   assign len_word  = (word == 16'd0) ? 16'd0 : word - 16'd1;
   assign count_inc = count_ff + 16'd1;

   // parallel sync compares, lowest entry wins
   always_comb begin
      entry_limit = (cfg.entry_count > ENTRY_COUNT_W'(NUM_APID_ENTRIES)) ?
                    ENTRY_COUNT_W'(NUM_APID_ENTRIES) : cfg.entry_count;
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = NUM_APID_ENTRIES - 1; i >= 0; i--) begin
         if ((ENTRY_COUNT_W'(i) < entry_limit) &&
             (word == {cfg.packet_version, cfg.type_bit, apid_entry[i]})) begin
            hit     = 1'b1;
            hit_idx = MATCH_W'(i);
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT: if (hvalid_ff && hit) phase_in = PH_SEQ;
         PH_SEQ:  if (count_ff != 16'd0) phase_in = PH_LEN;
         PH_LEN:  if (count_ff != 16'd0) phase_in = (len_word == 16'd0) ? PH_CRC : PH_PAY;
         PH_PAY:  if (count_inc >= plen_ff) phase_in = PH_CRC;
         PH_CRC:  if (count_ff != 16'd0) phase_in = PH_HUNT;
         default: phase_in = PH_HUNT;
      endcase
   end

   // datapath and results
   always_comb begin
      held_in   = held_ff;
      hvalid_in = hvalid_ff;
      count_in  = count_ff;
      plen_in   = plen_ff;
      crc_in    = crc_ff;
      match_in  = match_ff;

      push.push_count           = 2'd0;
      push.first.out_byte       = data_byte;
      push.first.packet_start   = 1'b0;
      push.first.packet_end     = 1'b0;
      push.first.field_part     = PART_HEADER;
      push.first.crc_good       = 1'b0;
      push.first.matched_entry  = match_ff;
      push.second.out_byte      = data_byte;
      push.second.packet_start  = 1'b0;
      push.second.packet_end    = 1'b0;
      push.second.field_part    = PART_HEADER;
      push.second.crc_good      = 1'b0;
      push.second.matched_entry = match_ff;

      unique case (phase_ff)
         PH_HUNT: begin
            if (!hvalid_ff) begin
               // first byte of the window, crc of it kept ready
               held_in   = data_byte;
               hvalid_in = 1'b1;
               crc_in    = crc_byte(CRC_INIT, data_byte);
            end else if (hit) begin
               match_in                  = hit_idx;
               push.push_count           = 2'd2;
               push.first.out_byte       = held_ff;
               push.first.packet_start   = 1'b1;
               push.first.matched_entry  = hit_idx;
               push.second.matched_entry = hit_idx;
               crc_in    = crc_next;
               hvalid_in = 1'b0;
               held_in   = 8'd0;
               count_in  = 16'd0;
            end else begin
               held_in = data_byte;
               crc_in  = crc_byte(CRC_INIT, data_byte);
            end
         end
         PH_SEQ: begin
            push.push_count = 2'd1;
            crc_in          = crc_next;
            count_in        = (count_ff == 16'd0) ? 16'd1 : 16'd0;
         end
         PH_LEN: begin
            push.push_count = 2'd1;
            crc_in          = crc_next;
            if (count_ff == 16'd0) begin
               held_in  = data_byte;
               count_in = 16'd1;
            end else begin
               plen_in  = len_word;
               count_in = 16'd0;
            end
         end
         PH_PAY: begin
            push.push_count       = 2'd1;
            push.first.field_part = PART_PAYLOAD;
            crc_in                = crc_next;
            count_in              = (count_inc >= plen_ff) ? 16'd0 : count_inc;
         end
         PH_CRC: begin
            push.push_count       = 2'd1;
            push.first.field_part = PART_CRC;
            if (count_ff == 16'd0) begin
               held_in  = data_byte;
               count_in = 16'd1;
            end else begin
               push.first.packet_end = 1'b1;
               push.first.crc_good   = (word == crc_ff);
               held_in   = 8'd0;
               hvalid_in = 1'b0;
               count_in  = 16'd0;
               plen_in   = 16'd0;
               crc_in    = CRC_INIT;
            end
         end
         default: begin
            hvalid_in = 1'b0;
         end
      endcase

      if (!accept) push.push_count = 2'd0;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         held_ff   <= 8'd0;
         hvalid_ff <= 1'b0;
         count_ff  <= 16'd0;
         plen_ff   <= 16'd0;
         crc_ff    <= CRC_INIT;
         match_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         hvalid_ff <= hvalid_in;
         count_ff  <= count_in;
         plen_ff   <= plen_in;
         crc_ff    <= crc_in;
         match_ff  <= match_in;
      end
   end

endmodule

// ----- src/spd_out_queue.sv -----
// ----------------------------------------------------------------------------
// spd_out_queue
// Four-entry result queue taking up to two results per cycle and handing
// one out per transfer; it also tells the input side when to stall.
// ----------------------------------------------------------------------------
module spd_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  spd_pkg::push_type   push,
   output logic                almost_full,
   output logic                out_valid,
   input  logic                out_stall,
   output spd_pkg::result_type out_item
);
   import spd_pkg::*;

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic                   pop;
   logic [QUEUE_PTR_W-1:0] wr_ptr_next;

   assign out_valid   = (count_ff != '0);
   assign pop         = out_valid & ~out_stall;
   assign almost_full = (count_ff > QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign out_item    = entry_ff[rd_ptr_ff];
   assign wr_ptr_next = wr_ptr_ff + QUEUE_PTR_W'(1);

   // pointer and fill arithmetic
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push.push_count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.push_count == 2'd2) entry_ff[wr_ptr_next] <= push.second;
   end

endmodule

// ----- src/space_packet_deframer_crc_top.sv -----
// ----------------------------------------------------------------------------
// space_packet_deframer_crc_top
// Space packet deframer with crc-16/ccitt-false check on the byte stream.
//
//   channel   direction   handshake                 content
//   req_      in          req_valid / req_stall     one received byte
//   rsp_      out         rsp_valid / rsp_stall     one passed byte plus flags
//   apb       in          psel / penable / pready   register writes and reads
//
// One byte is accepted per cycle while req_stall is low. A sync match
// gives two results from one byte, absorbed by the
// four-entry output queue, whose fill sets req_stall (high above two held).
// Reset clears the deframer to hunting and loads register defaults.
// rsp_stall only backs up the queue; the deframer runs until req_stall rises.
// ----------------------------------------------------------------------------
module space_packet_deframer_crc_top #(
   parameter int NUM_APID_ENTRIES = spd_pkg::DEFAULT_APID_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_packet_start,
   output logic                           rsp_packet_end,
   output logic [1:0]                     rsp_field_part,
   output logic                           rsp_crc_good,
   output logic [1:0]                     rsp_matched_entry,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [spd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import spd_pkg::*;

   cfg_type                                 cfg;
   logic [NUM_APID_ENTRIES-1:0][APID_W-1:0] apid_entry;
   push_type                                push;
   result_type                              head;
   logic                                    accept;
   logic                                    almost_full;

   assign req_stall = almost_full;
   assign accept    = req_valid & ~almost_full;

   // register file
   spd_csr #(
      .NUM_APID_ENTRIES (NUM_APID_ENTRIES)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .apid_entry (apid_entry)
   );

   // deframer
   spd_core #(
      .NUM_APID_ENTRIES (NUM_APID_ENTRIES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .cfg        (cfg),
      .apid_entry (apid_entry),
      .push       (push)
   );

   // result queue
   spd_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .almost_full (almost_full),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_item    (head)
   );

   assign rsp_out_byte      = head.out_byte;
   assign rsp_packet_start  = head.packet_start;
   assign rsp_packet_end    = head.packet_end;
   assign rsp_field_part    = head.field_part;
   assign rsp_crc_good      = head.crc_good;
   assign rsp_matched_entry = head.matched_entry;

endmodule
